[rtl/kwsc_pkg.sv]
`timescale 1ns / 1ps

package kwsc_pkg;

    // Alphabet size and letter index widths
    localparam int ALPHA = 26;
    localparam int IDX_W = 5;
    localparam int CNT_W = 5;

    // ASCII anchors
    localparam logic [7:0] UPPER_A = 8'd65;
    localparam logic [7:0] LOWER_A = 8'd97;

    // Operation codes
    localparam logic [2:0] OP_START  = 3'd0;
    localparam logic [2:0] OP_KEY    = 3'd1;
    localparam logic [2:0] OP_FINISH = 3'd2;
    localparam logic [2:0] OP_ENC    = 3'd3;
    localparam logic [2:0] OP_DEC    = 3'd4;

    // Controller states
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_WALK
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_key;
        logic append_key;
        logic walk_clear;
        logic walk_step;
        logic emit;
        logic sel_inv;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic walk_last;
        logic out_full;
    } stat_t;

endpackage

[rtl/kwsc_datapath.sv]
`timescale 1ns / 1ps

module kwsc_datapath (
    input  logic            clk,
    input  logic            rst_n,
    input  kwsc_pkg::cmd_t  cmd,
    output kwsc_pkg::stat_t stat,
    input  logic [7:0]      ch,
    input  logic            out_ready,
    output logic            out_valid,
    output logic [7:0]      out_char
);

    import kwsc_pkg::*;

    logic [IDX_W-1:0] subst_table_reg [ALPHA];
    logic [IDX_W-1:0] inverse_table_reg [ALPHA];
    logic [ALPHA-1:0] used_mask_reg;
    logic [ALPHA-1:0] used_mask_next;
    logic [CNT_W-1:0] fill_count_reg;
    logic [CNT_W-1:0] fill_count_next;
    logic [CNT_W-1:0] walk_idx_reg;
    logic [CNT_W-1:0] walk_idx_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_char_reg;
    logic [7:0]       out_char_next;

    logic             is_upper;
    logic             is_lower;
    logic             li_ok;
    logic [7:0]       diff_u;
    logic [7:0]       diff_l;
    logic [IDX_W-1:0] li;
    logic [IDX_W-1:0] app_idx;
    logic             app_req;
    logic             do_app;
    logic [IDX_W-1:0] lookup;

    // Letter decode, either case
    assign is_upper = (ch >= UPPER_A) && (ch < UPPER_A + 8'(ALPHA));
    assign is_lower = (ch >= LOWER_A) && (ch < LOWER_A + 8'(ALPHA));
    assign li_ok    = is_upper || is_lower;
    assign diff_u   = ch - UPPER_A;
    assign diff_l   = ch - LOWER_A;
    assign li       = is_upper ? diff_u[IDX_W-1:0] : diff_l[IDX_W-1:0];

    // Append one letter: from the key byte or from the finish walk
    assign app_idx = cmd.walk_step ? walk_idx_reg : li;
    assign app_req = cmd.walk_step || (cmd.append_key && li_ok);
    assign do_app  = app_req && !used_mask_reg[app_idx]
                     && (fill_count_reg < CNT_W'(ALPHA));

    always_comb
    begin
        used_mask_next  = used_mask_reg;
        fill_count_next = fill_count_reg;
        if (cmd.clear_key)
        begin
            used_mask_next  = '0;
            fill_count_next = '0;
        end
        else if (do_app)
        begin
            used_mask_next[app_idx] = 1'b1;
            fill_count_next         = fill_count_reg + 1'b1;
        end
    end

    // Walk index for the finish pass
    always_comb
    begin
        walk_idx_next = walk_idx_reg;
        if (cmd.walk_clear)
            walk_idx_next = '0;
        else if (cmd.walk_step)
            walk_idx_next = walk_idx_reg + 1'b1;
    end

    // Output register
    assign lookup = cmd.sel_inv ? inverse_table_reg[li] : subst_table_reg[li];

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_char_next  = li_ok ? (UPPER_A + 8'(lookup)) : ch;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Tables, identity after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ALPHA; i++)
            begin
                subst_table_reg[i]   <= IDX_W'(i);
                inverse_table_reg[i] <= IDX_W'(i);
            end
        end
        else if (do_app)
        begin
            subst_table_reg[fill_count_reg] <= app_idx;
            inverse_table_reg[app_idx]      <= fill_count_reg;
        end
    end

    // Control and key state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_mask_reg  <= '0;
            fill_count_reg <= '0;
            walk_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            used_mask_reg  <= used_mask_next;
            fill_count_reg <= fill_count_next;
            walk_idx_reg   <= walk_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result byte
    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_char       = out_char_reg;
    assign stat.walk_last = (walk_idx_reg == CNT_W'(ALPHA - 1));
    assign stat.out_full  = out_valid_reg;

`ifndef ASSERT_OFF
    // Fill count never passes the alphabet size
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= CNT_W'(ALPHA))
        else $error("fill count out of range");

    // Every used letter has exactly one table slot
    a_mask_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_mask_reg) == 32'(fill_count_reg))
        else $error("used mask and fill count disagree");

    // Tables stay inverse for used letters
    a_inverse: assert property (@(posedge clk) disable iff (!rst_n)
        (li_ok && used_mask_reg[li]) |-> subst_table_reg[inverse_table_reg[li]] == li)
        else $error("tables not inverse");
`endif

endmodule

[rtl/kwsc_ctrl.sv]
`timescale 1ns / 1ps

module kwsc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [2:0]      op,
    input  logic            out_ready,
    input  kwsc_pkg::stat_t stat,
    output kwsc_pkg::cmd_t  cmd
);

    import kwsc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // Take an item when idle and the output slot is free or draining
    assign in_ready = (state_reg == ST_IDLE) && (!stat.out_full || out_ready);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.sel_inv    = (op == OP_DEC);
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.clear_key  = (op == OP_START);
                    cmd.append_key = (op == OP_KEY);
                    cmd.emit       = (op == OP_ENC) || (op == OP_DEC);
                    if (op == OP_FINISH)
                    begin
                        cmd.walk_clear = 1'b1;
                        state_next     = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (stat.walk_last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // No item taken during the finish walk
    a_walk_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> !in_ready)
        else $error("item accepted during walk");

    // Walk ends after its last letter
    a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && stat.walk_last) |=> (state_reg == ST_IDLE))
        else $error("walk did not end");

    // A finish item starts the walk
    a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_FINISH) |=> (state_reg == ST_WALK))
        else $error("walk did not start");
`endif

endmodule

[rtl/keyword_substitution_cipher.sv]
`timescale 1ns / 1ps

// Keyword substitution cipher over A-Z.
// Input channel: in_valid/in_ready carry one item of op and ch.
//   op 0 starts a key, 1 adds a key character, 2 finishes the key,
//   3 enciphers ch, 4 deciphers ch; codes 5 to 7 are ignored.
// Output channel: out_valid/out_ready carry out_char, one item for each
//   encipher or decipher op and none for the others.
// Latency: a cipher result is valid the cycle after its item is accepted.
// Throughput: one item a cycle for start, key and cipher ops unless the
//   output stalls. A finish op holds the input while one counter walks
//   the alphabet a letter per cycle, adding unused ones to both tables.
// The output register lets a new item in while the held result is taken
//   in the same cycle; while the receiver stalls with a result held,
//   in_ready stays low.
// Reset: both tables return to the identity, the key is empty and the
//   output is empty; no clearing pass is needed.
module keyword_substitution_cipher (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] op,
    input  logic [7:0] ch,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_char
);

    import kwsc_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    kwsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    kwsc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .ch        (ch),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_char  (out_char)
    );

endmodule

[dv/keyword_substitution_cipher_test.sv]
`timescale 1ns / 1ps

module keyword_substitution_cipher_test;

    import kwsc_pkg::*;

    // Op codes the block ignores
    localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

    localparam int TARGET_ITEMS = 550;
    localparam int HOLD_CYCLES  = 80;
    localparam int STALL_LIMIT  = 1000;

    // Keeps its own copy of the key tables and the bytes still owed
    class cipher_scoreboard;
        logic [4:0]  fwd_map [ALPHA];
        logic [4:0]  inv_map [ALPHA];
        logic [25:0] used;
        int          filled;
        logic [7:0]  owed_q [$];
        int          errors;
        int          checked;

        function new();
            for (int i = 0; i < ALPHA; i++)
            begin
                fwd_map[i] = 5'(i);
                inv_map[i] = 5'(i);
            end
            used    = '0;
            filled  = 0;
            errors  = 0;
            checked = 0;
        endfunction

        // Letter index 0..25 for A-Z or a-z, -1 for any other byte
        function int letter_of(logic [7:0] c);
            if (c >= UPPER_A && c < UPPER_A + ALPHA)
                return int'(c - UPPER_A);
            if (c >= LOWER_A && c < LOWER_A + ALPHA)
                return int'(c - LOWER_A);
            return -1;
        endfunction

        function void take_letter(int idx);
            if (filled >= ALPHA || used[idx])
                return;
            used[idx]       = 1'b1;
            fwd_map[filled] = 5'(idx);
            inv_map[idx]    = 5'(filled);
            filled++;
        endfunction

        function void note_item(logic [2:0] op_v, logic [7:0] c);
            int li;
            li = letter_of(c);
            case (op_v)
                OP_START:
                begin
                    used   = '0;
                    filled = 0;
                end
                OP_KEY:
                    if (li >= 0)
                        take_letter(li);
                OP_FINISH:
                    for (int i = 0; i < ALPHA; i++)
                        take_letter(i);
                OP_ENC:
                    owed_q.push_back(li >= 0 ? UPPER_A + 8'(fwd_map[li]) : c);
                OP_DEC:
                    owed_q.push_back(li >= 0 ? UPPER_A + 8'(inv_map[li]) : c);
                default:
                    ;
            endcase
        endfunction

        function void check_result(logic [7:0] got);
            logic [7:0] want;
            if (owed_q.size() == 0)
            begin
                errors++;
                $error("out_char: no result expected, actual %02h", got);
                return;
            end
            want = owed_q.pop_front();
            checked++;
            if (got !== want)
            begin
                errors++;
                $error("out_char: expected %02h, actual %02h", want, got);
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [2:0] op        = OP_START;
    logic [7:0] ch        = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_char;

    cipher_scoreboard sb;
    bit calm         = 1'b0;
    bit hold_request = 1'b0;
    int hold_left    = 0;
    int holds_done   = 0;
    int items_sent   = 0;
    int keys_done    = 0;
    int quiet_cycles = 0;

    keyword_substitution_cipher u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .ch        (ch),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: check each accepted result, then pick next ready
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_char);
        if (hold_request && hold_left == 0)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
            holds_done++;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= calm || ($urandom_range(99, 0) >= 22);
        end
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("keyword_substitution_cipher_test failed");
            $finish;
        end
    end

    task automatic send_item(logic [2:0] op_v, logic [7:0] ch_v);
        int gap;
        gap = 0;
        // Each cycle idles with the same odds
        while (!calm && $urandom_range(99, 0) < 22)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= op_v;
        ch       <= ch_v;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_item(op_v, ch_v);
        if (op_v <= OP_DEC)
            items_sent++;
    endtask

    // Sender pauses until every owed result has come back
    task automatic wait_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    function automatic logic [7:0] pick_key_char();
        int r;
        r = $urandom_range(99, 0);
        if (r < 55)
            return UPPER_A + 8'($urandom_range(ALPHA - 1, 0));
        if (r < 85)
            return LOWER_A + 8'($urandom_range(ALPHA - 1, 0));
        return 8'($urandom_range(255, 0));
    endfunction

    function automatic logic [7:0] pick_text_char();
        int r;
        r = $urandom_range(99, 0);
        if (r < 40)
            return UPPER_A + 8'($urandom_range(ALPHA - 1, 0));
        if (r < 70)
            return LOWER_A + 8'($urandom_range(ALPHA - 1, 0));
        return 8'($urandom_range(255, 0));
    endfunction

    function automatic logic [2:0] pick_cipher_op();
        return $urandom_range(1, 0) ? OP_ENC : OP_DEC;
    endfunction

    task automatic load_key_text(string s);
        send_item(OP_START, 8'h00);
        for (int i = 0; i < s.len(); i++)
            send_item(OP_KEY, s[i]);
        send_item(OP_FINISH, 8'h00);
        keys_done++;
    endtask

    task automatic cipher_burst(int n);
        for (int i = 0; i < n; i++)
            send_item(pick_cipher_op(), pick_text_char());
    endtask

    initial
    begin
        int roll;
        int len;
        bit pressured;
        pressured = 1'b0;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Identity tables out of reset, letter boundaries, byte extremes
        send_item(OP_ENC, "A");
        send_item(OP_DEC, "z");
        send_item(OP_ENC, 8'h00);
        send_item(OP_DEC, 8'hFF);
        send_item(OP_ENC, "@");
        send_item(OP_DEC, "[");
        // Mixed-case key with a repeat and a non-letter
        send_item(OP_START, 8'hFF);
        send_item(OP_KEY, "Z");
        send_item(OP_KEY, "e");
        send_item(OP_KEY, "B");
        send_item(OP_KEY, "r");
        send_item(OP_KEY, "a");
        send_item(OP_KEY, "!");
        send_item(OP_KEY, "z");
        // Ignored op, then a lookup on a half-built table
        send_item(OP_FIRST_UNUSED, "q");
        send_item(OP_ENC, "z");
        send_item(OP_DEC, "e");
        // Finish twice, then a key char that must be ignored
        send_item(OP_FINISH, 8'h00);
        send_item(OP_FINISH, 8'hFF);
        send_item(OP_KEY, "q");
        send_item(OP_ENC, "a");
        send_item(OP_DEC, "Y");
        send_item(OP_LAST_UNUSED, 8'hFF);
        send_item(OP_FIRST_UNUSED + 3'd1, 8'h00);
        wait_drain();

        // Every letter given by the key itself, table full before finish
        load_key_text("The quick brown fox jumps over the lazy dog");
        cipher_burst(12);

        while (items_sent < TARGET_ITEMS)
        begin
            // Receiver holds off while the sender keeps offering items
            if (!pressured && items_sent > 200)
            begin
                pressured    = 1'b1;
                hold_request = 1'b1;
                cipher_burst(12);
                wait_drain();
            end
            calm = (items_sent >= 320 && items_sent < 420);
            roll = $urandom_range(99, 0);
            if (roll < 78)
            begin
                // Well-formed key load followed by a message
                len = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 20)
                                                  : $urandom_range(12, 0);
                send_item(OP_START, 8'($urandom_range(255, 0)));
                for (int i = 0; i < len; i++)
                    send_item(OP_KEY, pick_key_char());
                send_item(OP_FINISH, 8'($urandom_range(255, 0)));
                keys_done++;
                cipher_burst($urandom_range(20, 4));
            end
            else if (roll < 90)
            begin
                // Broken key load: cipher on stale or partial tables
                send_item(OP_START, 8'($urandom_range(255, 0)));
                len = $urandom_range(8, 0);
                for (int i = 0; i < len; i++)
                    send_item(OP_KEY, pick_key_char());
                cipher_burst($urandom_range(6, 1));
                if ($urandom_range(1, 0))
                    send_item(OP_KEY, pick_key_char());
            end
            else
            begin
                // Raw noise over the whole op and byte space
                len = $urandom_range(8, 3);
                for (int i = 0; i < len; i++)
                    send_item(3'($urandom_range(7, 0)), 8'($urandom_range(255, 0)));
            end
        end
        calm = 1'b0;

        wait_drain();
        repeat (4) @(posedge clk);

        if (sb.pending() != 0)
        begin
            sb.errors += sb.pending();
            $error("out_char: %0d results never arrived", sb.pending());
        end
        $display("run covered %0d items, %0d finished keys, %0d results checked",
                 items_sent, keys_done, sb.checked);
        $display("receiver hold-offs: %0d, mismatches: %0d", holds_done, sb.errors);
        if (sb.errors == 0)
            $display("keyword_substitution_cipher_test passed");
        else
            $display("keyword_substitution_cipher_test failed");
        $finish;
    end

endmodule

[sim.f]
rtl/kwsc_pkg.sv
rtl/kwsc_datapath.sv
rtl/kwsc_ctrl.sv
rtl/keyword_substitution_cipher.sv
dv/keyword_substitution_cipher_test.sv
